[rtl/cid_pkg.sv]
// Shared types and constants for the caller number frame extractor.
package cid_pkg;

    localparam int MAX_NUMBER_LEN = 25;
    localparam int CNT_W  = $clog2(MAX_NUMBER_LEN + 1);
    localparam int ADDR_W = $clog2(MAX_NUMBER_LEN);

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_START_FIRST  = 2'd0;
    localparam logic [1:0] REG_START_SECOND = 2'd1;
    localparam logic [1:0] REG_END_FIRST    = 2'd2;
    localparam logic [1:0] REG_END_SECOND   = 2'd3;

    localparam logic [7:0] RST_START_FIRST  = 8'd2;
    localparam logic [7:0] RST_START_SECOND = 8'd10;
    localparam logic [7:0] RST_END_FIRST    = 8'd8;
    localparam logic [7:0] RST_END_SECOND   = 8'd1;

    typedef enum logic [1:0] {
        ST_HUNT,
        ST_COLLECT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [7:0] start_first;
        logic [7:0] start_second;
        logic [7:0] end_first;
        logic [7:0] end_second;
    } t_cfg;

    typedef struct packed {
        logic hunt_take;
        logic collect_take;
        logic emit_next;
    } t_dp_cmd;

    typedef struct packed {
        logic start_hit;
        logic frame_done;
        logic last;
    } t_dp_stat;

endpackage

[rtl/cid_if.sv]
// Request channel interfaces for received bytes and extracted number bytes.
interface cid_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cid_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] id_byte;
    logic       is_empty;
    logic       is_last;

    modport source (output valid, output id_byte, output is_empty, output is_last,
                    input ready);
    modport sink   (input valid, input id_byte, input is_empty, input is_last,
                    output ready);
endinterface

[rtl/cid_ctrl.sv]
// Controller state machine: hunt, collect and emit phases of a frame.
module cid_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    input  cid_pkg::t_dp_stat i_stat,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output cid_pkg::t_dp_cmd  o_cmd
);
    import cid_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        case (r_state)
            ST_HUNT: begin
                o_in_ready      = 1'b1;
                o_cmd.hunt_take = i_in_valid;
                if (i_in_valid && i_stat.start_hit) begin
                    n_state = ST_COLLECT;
                end
            end
            ST_COLLECT: begin
                o_in_ready         = 1'b1;
                o_cmd.collect_take = i_in_valid;
                if (i_in_valid && i_stat.frame_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_stat.last) begin
                        n_state = ST_HUNT;
                    end else begin
                        o_cmd.emit_next = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_HUNT;
            end
        endcase
    end

endmodule

[rtl/cid_datapath.sv]
// Datapath: pair matching, number store, fill count and read index.
module cid_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cid_pkg::t_cfg     i_cfg,
    input  logic [7:0]        i_rx_byte,
    input  cid_pkg::t_dp_cmd  i_cmd,
    output cid_pkg::t_dp_stat o_stat,
    output logic [7:0]        o_id_byte,
    output logic              o_is_empty,
    output logic              o_is_last
);
    import cid_pkg::*;

    logic [7:0]        r_prev;
    logic [CNT_W-1:0]  r_fill;
    logic [ADDR_W-1:0] r_rd_idx;
    logic [7:0]        r_store [MAX_NUMBER_LEN];

    logic             full;
    logic             end_hit;
    logic [CNT_W-1:0] fill_inc;
    logic [CNT_W-1:0] fill_trim;

    assign full    = (r_fill == CNT_W'(MAX_NUMBER_LEN));
    assign end_hit = (i_rx_byte == i_cfg.end_second) && (r_prev == i_cfg.end_first);
    assign fill_inc  = full ? r_fill : r_fill + CNT_W'(1);
    assign fill_trim = (fill_inc >= CNT_W'(2)) ? fill_inc - CNT_W'(2) : '0;

    assign o_stat.start_hit  = (i_rx_byte == i_cfg.start_second) &&
                               (r_prev == i_cfg.start_first);
    assign o_stat.frame_done = full || end_hit;
    assign o_stat.last       = o_is_last;

    // An empty frame yields a single zero byte flagged as both empty and last.
    assign o_is_empty = (r_fill == '0);
    assign o_is_last  = o_is_empty || ((CNT_W'(r_rd_idx) + CNT_W'(1)) == r_fill);
    assign o_id_byte  = o_is_empty ? 8'd0 : r_store[r_rd_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= '0;
            r_fill   <= '0;
            r_rd_idx <= '0;
        end else begin
            if (i_cmd.hunt_take) begin
                if (o_stat.start_hit) begin
                    r_fill <= '0;
                end else begin
                    r_prev <= i_rx_byte;
                end
            end
            if (i_cmd.collect_take) begin
                r_rd_idx <= '0;
                if (end_hit) begin
                    r_fill <= fill_trim;
                end else begin
                    r_fill <= fill_inc;
                    r_prev <= i_rx_byte;
                end
            end
            if (i_cmd.emit_next) begin
                r_rd_idx <= r_rd_idx + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.collect_take && !full) begin
            r_store[r_fill[ADDR_W-1:0]] <= i_rx_byte;
        end
    end

endmodule

[rtl/caller_id_frame_extractor.sv]
// Top level of the caller number frame extractor with its register port.
//
// Usage: received bytes arrive as requests on i_rx (valid/ready). While
// hunting, the block looks for the start pair; it then stores up to
// MAX_NUMBER_LEN bytes while watching for the end pair, which removes the
// last two stored bytes. A full store also closes the frame.
// When a frame closes, the stored bytes leave in order as requests on o_id,
// the final one flagged is_last. A frame with no bytes gives one request
// with id_byte zero and both is_empty and is_last set.
// Throughput: bytes are taken one per cycle while hunting and collecting.
// Once the byte that closes a frame is taken, the emit phase issues one
// request per cycle while the receiver is ready, one per stored byte (one for an empty
// frame); the byte stream is held off until the last request is taken.
// The emit phase walks the number store through a single read index.
// If the receiver stalls, the current request holds and nothing advances.
// Reset (synchronous, active low) returns the block to hunting, clears the
// previous byte and fill count and loads the default pair registers; the
// store contents are not cleared, as only bytes of the current frame are read.
// The pair registers are written over the APB-style port and read back too.
module caller_id_frame_extractor (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    cid_in_if.sink                      i_rx,
    cid_out_if.source                   o_id,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cid_pkg::PADDR_W-1:0] paddr,
    input  logic [cid_pkg::PDATA_W-1:0] pwdata,
    output logic [cid_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import cid_pkg::*;

    t_cfg     r_cfg;
    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     cfg_wr;
    logic [7:0] rd_val;

    // The register port never inserts wait states.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_first  <= RST_START_FIRST;
            r_cfg.start_second <= RST_START_SECOND;
            r_cfg.end_first    <= RST_END_FIRST;
            r_cfg.end_second   <= RST_END_SECOND;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_START_FIRST:  r_cfg.start_first  <= pwdata[7:0];
                REG_START_SECOND: r_cfg.start_second <= pwdata[7:0];
                REG_END_FIRST:    r_cfg.end_first    <= pwdata[7:0];
                REG_END_SECOND:   r_cfg.end_second   <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_START_FIRST:  rd_val = r_cfg.start_first;
            REG_START_SECOND: rd_val = r_cfg.start_second;
            REG_END_FIRST:    rd_val = r_cfg.end_first;
            REG_END_SECOND:   rd_val = r_cfg.end_second;
            default:          rd_val = '0;
        endcase
    end
    assign prdata = {{(PDATA_W-8){1'b0}}, rd_val};

    cid_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_rx.valid),
        .i_out_ready (o_id.ready),
        .i_stat      (stat),
        .o_in_ready  (i_rx.ready),
        .o_out_valid (o_id.valid),
        .o_cmd       (cmd)
    );

    cid_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_rx_byte  (i_rx.rx_byte),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_id_byte  (o_id.id_byte),
        .o_is_empty (o_id.is_empty),
        .o_is_last  (o_id.is_last)
    );

endmodule

[rtl/cid_checker.sv]
// Port-level checks for the caller number frame extractor, bound to the top level.
module cid_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_id_byte,
    input logic       i_is_empty,
    input logic       i_is_last
);

    // Byte intake and number output never overlap.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input taken while a number byte is pending");

    // An empty result is the only and final one, with a zero byte.
    a_empty_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_is_empty) |-> (i_is_last && (i_id_byte == 8'd0)))
        else $error("empty result malformed");

    // Leaving reset, the block is hunting and shows no result.
    a_reset_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> (!i_out_valid && i_in_ready))
        else $error("block not idle after reset");

    // A stalled result holds its payload.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_id_byte) && $stable(i_is_empty) &&
             $stable(i_is_last)))
        else $error("stalled result changed");

endmodule

bind caller_id_frame_extractor cid_checker u_cid_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_rx.ready),
    .i_out_valid (o_id.valid),
    .i_out_ready (o_id.ready),
    .i_id_byte   (o_id.id_byte),
    .i_is_empty  (o_id.is_empty),
    .i_is_last   (o_id.is_last)
);
